### design/pse_pkg.sv
`default_nettype none
package pse_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int DATA_WIDTH  = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DIV_CNT_W   = $clog2(DATA_WIDTH);

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [CNT_W-1:0]      count_t;
  typedef logic [ADDR_W-1:0]     addr_t;

  typedef enum logic [2:0] {
    MODE_PUSH = 3'd0,
    MODE_ADD  = 3'd1,
    MODE_SUB  = 3'd2,
    MODE_DIV  = 3'd3,
    MODE_MUL  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_UNDER = 2'd1,
    STAT_DIVZ  = 2'd2,
    STAT_OVER  = 2'd3
  } status_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    data_t wdata;
    addr_t raddr;
  } mem_req_t;

endpackage
`default_nettype wire

### design/pse_stack_mem.sv
`default_nettype none
module pse_stack_mem (
  input  wire logic              clk,
  input  wire pse_pkg::mem_req_t req,
  output pse_pkg::data_t         rd_data
);
  import pse_pkg::*;

  data_t mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data <= mem[req.raddr];
  end

endmodule
`default_nettype wire

### design/pse_divider.sv
`default_nettype none
// Restoring divider on magnitudes, one quotient bit per cycle, truncating.
module pse_divider (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire pse_pkg::data_t dividend,
  input  wire pse_pkg::data_t divisor,
  output logic                done,
  output pse_pkg::data_t      quotient
);
  import pse_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  data_t                rem;
  data_t                quo;
  data_t                dvs;
  logic                 neg;

  logic [DATA_WIDTH:0]  shifted;
  logic [DATA_WIDTH:0]  diff;
  logic                 qbit;
  data_t                rem_next;

  always_comb begin
    shifted  = {rem, quo[DATA_WIDTH-1]};
    diff     = shifted - {1'b0, dvs};
    qbit     = ~diff[DATA_WIDTH];
    rem_next = qbit ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
  end

  assign quotient = neg ? (~quo + data_t'(1)) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(DATA_WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend[DATA_WIDTH-1] ? (~dividend + data_t'(1)) : dividend;
      dvs <= divisor[DATA_WIDTH-1] ? (~divisor + data_t'(1)) : divisor;
      neg <= dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[DATA_WIDTH-2:0], qbit};
    end
  end

endmodule
`default_nettype wire

### design/postfix_stack_evaluator.sv
`default_nettype none
// One item at a time. From accept to result load, push, ignored modes and
// error outcomes go straight to S_DONE; add, subtract and multiply pass
// through S_READ; divide passes through S_READ and S_DIV, waiting on the
// one-bit-per-cycle divider. The next item can be accepted in the cycle
// after the result is loaded, even while that result still waits.
// Reset clears the stack depth and the output valid; stack RAM keeps its data.
module postfix_stack_evaluator (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [2:0]                mode,
  input  wire logic signed [31:0]        value,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic signed [31:0]             top_value,
  output logic [pse_pkg::CNT_W-1:0]      depth,
  output logic [1:0]                     status
);
  import pse_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t   state;
  state_t   state_next;
  count_t   count;
  count_t   count_next;
  data_t    top_reg;
  data_t    top_reg_next;
  mode_t    op;
  status_t  stat;
  status_t  stat_next;
  mem_req_t mreq;
  data_t    rd_data;
  logic     div_start;
  logic     div_done;
  data_t    div_quo;
  data_t    lhs;
  data_t    res;
  logic     out_load;
  addr_t    lhs_addr;

  pse_stack_mem u_mem (
    .clk     (clk),
    .req     (mreq),
    .rd_data (rd_data)
  );

  pse_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rd_data),
    .divisor  (top_reg),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign in_ready = (state == S_IDLE);
  assign lhs      = rd_data;
  assign lhs_addr = addr_t'(count - count_t'(2));
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  // top entry stays cached in top_reg, so only the left operand is read
  always_comb begin
    unique case (op)
      MODE_ADD: res = lhs + top_reg;
      MODE_SUB: res = lhs - top_reg;
      MODE_MUL: res = lhs * top_reg;
      default:  res = div_quo;
    endcase
  end

  always_comb begin
    state_next   = state;
    count_next   = count;
    top_reg_next = top_reg;
    stat_next    = stat;
    div_start    = 1'b0;
    mreq.we      = 1'b0;
    mreq.waddr   = lhs_addr;
    mreq.wdata   = res;
    mreq.raddr   = lhs_addr;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DONE;
          stat_next  = STAT_OK;
          unique case (mode)
            MODE_PUSH: begin
              if (count < count_t'(STACK_DEPTH)) begin
                mreq.we      = 1'b1;
                mreq.waddr   = addr_t'(count);
                mreq.wdata   = value;
                top_reg_next = value;
                count_next   = count + count_t'(1);
              end else begin
                stat_next = STAT_OVER;
              end
            end
            MODE_ADD, MODE_SUB, MODE_DIV, MODE_MUL: begin
              if (count < count_t'(2)) begin
                count_next = '0;
                stat_next  = STAT_UNDER;
              end else if (mode == MODE_DIV && top_reg == '0) begin
                stat_next = STAT_DIVZ;
              end else begin
                state_next = S_READ;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        if (op == MODE_DIV) begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end else begin
          mreq.we      = 1'b1;
          top_reg_next = res;
          count_next   = count - count_t'(1);
          state_next   = S_DONE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          mreq.we      = 1'b1;
          top_reg_next = res;
          count_next   = count - count_t'(1);
          state_next   = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    top_reg <= top_reg_next;
    stat    <= stat_next;
    if (state == S_IDLE && in_valid) begin
      op <= mode_t'(mode);
    end
    if (out_load) begin
      top_value <= (count == '0) ? '0 : top_reg;
      depth     <= count;
      status    <= stat;
    end
  end

endmodule
`default_nettype wire
